[rtl/core/ffcalc_pkg.sv]
// Shared types and constants for the four-function calculator core.
package ffcalc_pkg;

    typedef enum logic [1:0] {
        ACT_DIGIT  = 2'd0,
        ACT_OPER   = 2'd1,
        ACT_EQUALS = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } t_op_code;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_FIN  = 2'd2
    } t_state;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned DivCntWidth = 5;

endpackage

[rtl/core/four_function_calculator_core.sv]
// Top level of the four-function calculator core with its shared iterative divider.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------------
//  key     | in        | i_valid / o_ready  | i_action, i_digit, i_operator
//  display | out       | o_valid / i_ready  | o_display_value, o_entering_flag
//
// Digit and clear words, and equals or operator words that do not apply a pending division
// with a nonzero divisor, finish in the cycle they are accepted. A word that applies such a
// division loads the divider, runs 32 restoring subtract-and-shift steps and then signs
// the quotient once the display register is free. Reset is synchronous, active low
// and clears all calculator state. A new key word is taken only while the divider is idle
// and the display register is empty or being emptied, so a stalled output holds the block.
module four_function_calculator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_digit,
    input  logic [1:0]  i_operator,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_display_value,
    output logic        o_entering_flag
);
    import ffcalc_pkg::*;

    // Architectural calculator state.
    t_state                 r_state, n_state;
    logic [DataWidth-1:0]   r_acc, n_acc;
    logic [DataWidth-1:0]   r_entry, n_entry;
    t_op_code               r_pend, n_pend;
    logic                   r_entering, n_entering;

    // Display register that separates the key side from the display side.
    logic                   r_out_valid, n_out_valid;
    logic [DataWidth-1:0]   r_out_value, n_out_value;
    logic                   r_out_entering, n_out_entering;

    // Shared restoring divider working on magnitudes.
    logic [DataWidth-1:0]   r_rem, n_rem;
    logic [DataWidth-1:0]   r_quo, n_quo;
    logic [DataWidth-1:0]   r_dvs, n_dvs;
    logic                   r_neg, n_neg;
    logic                   r_div_eq, n_div_eq;
    logic [DivCntWidth-1:0] r_cnt, n_cnt;

    logic                   out_free;
    logic                   in_accept;
    logic                   div_start;
    logic [DataWidth-1:0]   applied;
    logic [DataWidth-1:0]   result;
    logic [DataWidth-1:0]   entry_shift;
    logic [DataWidth-1:0]   product;
    logic [DataWidth-1:0]   quotient;
    logic [DataWidth:0]     rem_shift;
    logic [DataWidth:0]     rem_diff;
    logic [DataWidth-1:0]   acc_mag;
    logic [DataWidth-1:0]   entry_mag;

    assign out_free  = !r_out_valid || i_ready;
    assign o_ready   = (r_state == ST_IDLE) && out_free;
    assign in_accept = i_valid && o_ready;

    assign o_valid         = r_out_valid;
    assign o_display_value = r_out_value;
    assign o_entering_flag = r_out_entering;

    // Entry times ten plus digit, built from two shifts and adds.
    assign entry_shift = {r_entry[DataWidth-4:0], 3'b000}
                       + {r_entry[DataWidth-2:0], 1'b0}
                       + {{(DataWidth-4){1'b0}}, i_digit};

    assign product   = r_acc * r_entry;
    assign acc_mag   = r_acc[DataWidth-1] ? (~r_acc + 1'b1) : r_acc;
    assign entry_mag = r_entry[DataWidth-1] ? (~r_entry + 1'b1) : r_entry;

    // A division with a zero divisor leaves the accumulator as it is, so
    // only a nonzero divisor sends the block through the divider.
    assign div_start = (r_pend == OP_DIV) && (r_entry != '0);

    // Pending operation applied combinationally; division is handled apart.
    always_comb begin
        case (r_pend)
            OP_ADD:  applied = r_acc + r_entry;
            OP_SUB:  applied = r_acc - r_entry;
            OP_MUL:  applied = product;
            default: applied = r_acc;
        endcase
        result = (r_pend == OP_NONE) ? r_entry : applied;
    end

    assign rem_shift = {r_rem, r_quo[DataWidth-1]};
    assign rem_diff  = rem_shift - {1'b0, r_dvs};
    assign quotient  = r_neg ? (~r_quo + 1'b1) : r_quo;

    always_comb begin
        n_state        = r_state;
        n_acc          = r_acc;
        n_entry        = r_entry;
        n_pend         = r_pend;
        n_entering     = r_entering;
        n_out_valid    = r_out_valid && !i_ready;
        n_out_value    = r_out_value;
        n_out_entering = r_out_entering;
        n_rem          = r_rem;
        n_quo          = r_quo;
        n_dvs          = r_dvs;
        n_neg          = r_neg;
        n_div_eq       = r_div_eq;
        n_cnt          = r_cnt;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    case (t_action'(i_action))
                        ACT_DIGIT: begin
                            n_entry        = r_entering ? entry_shift
                                                        : {{(DataWidth-4){1'b0}}, i_digit};
                            n_entering     = 1'b1;
                            n_out_valid    = 1'b1;
                            n_out_value    = n_entry;
                            n_out_entering = 1'b1;
                        end
                        ACT_OPER, ACT_EQUALS: begin
                            n_entering = 1'b0;
                            n_div_eq   = (t_action'(i_action) == ACT_EQUALS);
                            if (t_action'(i_action) == ACT_OPER) begin
                                n_pend  = t_op_code'({1'b0, i_operator} + 3'd1);
                                n_entry = '0;
                            end else begin
                                n_pend  = OP_NONE;
                            end
                            if (div_start) begin
                                n_rem   = '0;
                                n_quo   = acc_mag;
                                n_dvs   = entry_mag;
                                n_neg   = r_acc[DataWidth-1] ^ r_entry[DataWidth-1];
                                n_cnt   = '1;
                                n_state = ST_DIV;
                            end else begin
                                n_acc          = result;
                                if (t_action'(i_action) == ACT_EQUALS) begin
                                    n_entry = result;
                                end
                                n_out_valid    = 1'b1;
                                n_out_value    = result;
                                n_out_entering = 1'b0;
                            end
                        end
                        default: begin
                            n_acc          = '0;
                            n_entry        = '0;
                            n_pend         = OP_NONE;
                            n_entering     = 1'b0;
                            n_out_valid    = 1'b1;
                            n_out_value    = '0;
                            n_out_entering = 1'b0;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                // One restoring step: shift in the next dividend bit and
                // keep the difference when it does not go negative.
                if (!rem_diff[DataWidth]) begin
                    n_rem = rem_diff[DataWidth-1:0];
                    n_quo = {r_quo[DataWidth-2:0], 1'b1};
                end else begin
                    n_rem = rem_shift[DataWidth-1:0];
                    n_quo = {r_quo[DataWidth-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_acc = quotient;
                    if (r_div_eq) begin
                        n_entry = quotient;
                    end
                    n_out_valid    = 1'b1;
                    n_out_value    = quotient;
                    n_out_entering = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_entry     <= '0;
            r_pend      <= OP_NONE;
            r_entering  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_entry     <= n_entry;
            r_pend      <= n_pend;
            r_entering  <= n_entering;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value    <= n_out_value;
        r_out_entering <= n_out_entering;
        r_rem          <= n_rem;
        r_quo          <= n_quo;
        r_dvs          <= n_dvs;
        r_neg          <= n_neg;
        r_div_eq       <= n_div_eq;
        r_cnt          <= n_cnt;
    end

endmodule
